>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Sampling on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/blfe_pkg.sv
// ----------------------------------------------------------------------------
// blfe_pkg
// Types, sizes, encodings and helpers of the branch label fixup emitter.
// ----------------------------------------------------------------------------
package blfe_pkg;

  localparam int CODE_WORDS  = 4096;
  localparam int MAX_LABELS  = 256;
  localparam int MAX_PATCHES = 256;

  localparam int CA_W   = $clog2(CODE_WORDS);
  localparam int POS_W  = CA_W + 1;
  localparam int OFF_W  = POS_W + 1;
  localparam int LA_W   = $clog2(MAX_LABELS);
  localparam int LCNT_W = $clog2(MAX_LABELS + 1);
  localparam int PA_W   = $clog2(MAX_PATCHES);
  localparam int PCNT_W = $clog2(MAX_PATCHES + 1);

  localparam int OP_W    = 3;
  localparam int ID_W    = 8;
  localparam int COND_W  = 4;
  localparam int WORD_W  = 32;
  localparam int RADDR_W = 12;
  localparam int LIMIT_W = 13;
  localparam int POSO_W  = 13;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic [WORD_W-1:0] B_BASE  = 32'h1400_0000;
  localparam logic [WORD_W-1:0] BC_BASE = 32'h5400_0000;
  localparam logic [WORD_W-1:0] B_KEEP  = 32'hFC00_0000;
  localparam logic [WORD_W-1:0] BC_KEEP = 32'hFF00_001F;
  localparam int OFF_B_W  = 26;
  localparam int OFF_C_W  = 19;
  localparam int OFF_C_LSB = 5;

  typedef enum logic [OP_W-1:0] {
    OP_NEW_LABEL = 3'd0,
    OP_BIND      = 3'd1,
    OP_EMIT      = 3'd2,
    OP_BRANCH    = 3'd3,
    OP_BCOND     = 3'd4,
    OP_FINALIZE  = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FP_LAB,
    S_FP_CHK,
    S_FIN_OUT
  } state_t;

  typedef struct packed {
    logic             bound;
    logic [POS_W-1:0] pos;
  } label_ent_t;

  // at keeps the full position, a branch recorded at a full store is past the end.
  typedef struct packed {
    logic [ID_W-1:0]  lab;
    logic [POS_W-1:0] at;
    logic             is_cond;
  } patch_ent_t;

  typedef struct packed {
    logic [ID_W-1:0]   new_label;
    logic              label_ok;
    logic [POSO_W-1:0] position;
    logic [WORD_W-1:0] read_data;
    logic              error_flag;
    logic              finalize_ok;
  } blfe_res_t;

  // B keeps the opcode bits, B.cond keeps opcode and condition.
  function automatic logic [WORD_W-1:0] blfe_encode(input logic [WORD_W-1:0]  base,
                                                    input logic [OFF_B_W-1:0] off,
                                                    input logic               is_cond);
    logic [WORD_W-1:0] w;
    if (is_cond) begin
      w = (base & BC_KEEP) | (WORD_W'(off[OFF_C_W-1:0]) << OFF_C_LSB);
    end else begin
      w = (base & B_KEEP) | WORD_W'(off);
    end
    return w;
  endfunction

endpackage

>>> rtl/blfe_ram.sv
// ----------------------------------------------------------------------------
// blfe_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module blfe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/blfe_seq.sv
// ----------------------------------------------------------------------------
// blfe_seq
// Operation sequencer: code, label and patch memories, counters, error flag,
// and the finalize walk over the patch list.
// ----------------------------------------------------------------------------
module blfe_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blfe_pkg::OP_W-1:0]     op,
  input  logic [blfe_pkg::ID_W-1:0]     label_id,
  input  logic [blfe_pkg::COND_W-1:0]   cond_code,
  input  logic [blfe_pkg::WORD_W-1:0]   instr_word,
  input  logic [blfe_pkg::RADDR_W-1:0]  read_addr,
  input  logic [blfe_pkg::LIMIT_W-1:0]  code_limit,
  output logic                          res_valid,
  input  logic                          res_ready,
  output blfe_pkg::blfe_res_t           res
);
  import blfe_pkg::*;

  state_t            state, state_next;
  logic [POS_W-1:0]  write_pos, write_pos_next;
  logic              err, err_next;
  logic [LCNT_W-1:0] label_count, label_count_next;
  logic [PCNT_W-1:0] patch_count, patch_count_next;
  logic [PA_W-1:0]   fidx, fidx_next;
  logic              fin_ok, fin_ok_next;

  op_t               op_q;
  logic [ID_W-1:0]   lab_q;
  logic [COND_W-1:0] cond_q;
  logic [WORD_W-1:0] word_q;
  logic [RADDR_W-1:0] raddr_q;

  logic              lt_we, lt_re;
  logic [LA_W-1:0]   lt_waddr, lt_raddr;
  label_ent_t        lt_wdata, lt_rdata;
  logic              ct_we, ct_re;
  logic [CA_W-1:0]   ct_waddr, ct_raddr;
  logic [WORD_W-1:0] ct_wdata, ct_rdata;
  logic              pt_we, pt_re;
  logic [PA_W-1:0]   pt_waddr, pt_raddr;
  patch_ent_t        pt_wdata, pt_rdata;

  logic [POS_W-1:0]  limit;
  logic              space_ok;
  logic              lab_alloc, fp_lab_ok, fp_at_ok;
  logic [POS_W-1:0]  from_pos;
  logic signed [OFF_W-1:0] off;
  logic [OFF_B_W-1:0] off_ext;
  logic [WORD_W-1:0] br_base, enc_base, enc_word;
  logic              enc_cond;

  blfe_ram #(.DEPTH(MAX_LABELS), .WIDTH($bits(label_ent_t))) u_label_ram (
    .clk(clk), .we(lt_we), .waddr(lt_waddr), .wdata(lt_wdata),
    .re(lt_re), .raddr(lt_raddr), .rdata(lt_rdata)
  );

  blfe_ram #(.DEPTH(CODE_WORDS), .WIDTH(WORD_W)) u_code_ram (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .re(ct_re), .raddr(ct_raddr), .rdata(ct_rdata)
  );

  blfe_ram #(.DEPTH(MAX_PATCHES), .WIDTH($bits(patch_ent_t))) u_patch_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .re(pt_re), .raddr(pt_raddr), .rdata(pt_rdata)
  );

  assign limit    = (32'(code_limit) > CODE_WORDS) ? POS_W'(CODE_WORDS) : POS_W'(code_limit);
  assign space_ok = write_pos < limit;

  assign lab_alloc = 32'(lab_q) < 32'(label_count);
  assign fp_lab_ok = 32'(pt_rdata.lab) < 32'(label_count);
  assign fp_at_ok  = 32'(pt_rdata.at) < CODE_WORDS;

  // One subtractor serves bound branches and patch resolution. Offsets stay
  // within both branch ranges for the 4096-word code store.
  assign from_pos = (state == S_FP_CHK) ? pt_rdata.at : write_pos;
  assign off      = $signed({1'b0, lt_rdata.pos}) - $signed({1'b0, from_pos});
  assign off_ext  = OFF_B_W'(off);
  assign br_base  = (op_q == OP_BCOND) ? (BC_BASE | WORD_W'(cond_q)) : B_BASE;
  assign enc_base = (state == S_FP_CHK) ? ct_rdata : br_base;
  assign enc_cond = (state == S_FP_CHK) ? pt_rdata.is_cond : (op_q == OP_BCOND);
  assign enc_word = blfe_encode(enc_base, off_ext, enc_cond);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_pos   <= '0;
      err         <= 1'b0;
      label_count <= '0;
      patch_count <= '0;
      fidx        <= '0;
      fin_ok      <= 1'b0;
    end else begin
      state       <= state_next;
      write_pos   <= write_pos_next;
      err         <= err_next;
      label_count <= label_count_next;
      patch_count <= patch_count_next;
      fidx        <= fidx_next;
      fin_ok      <= fin_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q    <= op_t'(op);
      lab_q   <= label_id;
      cond_q  <= cond_code;
      word_q  <= instr_word;
      raddr_q <= read_addr;
    end
  end

  always_comb begin
    logic              do_put;
    logic [WORD_W-1:0] put_val;
    logic [ID_W-1:0]   r_nl;
    logic              r_ok;
    logic [WORD_W-1:0] r_rd;
    logic              r_fin;

    do_put  = 1'b0;
    put_val = word_q;
    r_nl    = '0;
    r_ok    = 1'b0;
    r_rd    = '0;
    r_fin   = 1'b0;

    state_next       = state;
    write_pos_next   = write_pos;
    err_next         = err;
    label_count_next = label_count;
    patch_count_next = patch_count;
    fidx_next        = fidx;
    fin_ok_next      = fin_ok;

    in_ready  = 1'b0;
    res_valid = 1'b0;

    lt_we    = 1'b0;
    lt_waddr = LA_W'(lab_q);
    lt_wdata = '{bound: 1'b1, pos: write_pos};
    lt_re    = 1'b0;
    lt_raddr = LA_W'(label_id);
    ct_we    = 1'b0;
    ct_waddr = CA_W'(write_pos);
    ct_wdata = put_val;
    ct_re    = 1'b0;
    ct_raddr = CA_W'(read_addr);
    pt_we    = 1'b0;
    pt_waddr = PA_W'(patch_count);
    pt_wdata = '{lab: lab_q, at: write_pos, is_cond: (op_q == OP_BCOND)};
    pt_re    = 1'b0;
    pt_raddr = fidx;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lt_re      = 1'b1;
          ct_re      = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (op_q == OP_FINALIZE && !err && patch_count != '0) begin
          fidx_next  = PA_W'(patch_count - 1'b1);
          pt_re      = 1'b1;
          pt_raddr   = fidx_next;
          state_next = S_FP_LAB;
        end else if (res_ready) begin
          res_valid  = 1'b1;
          state_next = S_IDLE;
          case (op_q)
            OP_NEW_LABEL: begin
              if (32'(label_count) >= MAX_LABELS) begin
                err_next = 1'b1;
              end else begin
                lt_we            = 1'b1;
                lt_waddr         = LA_W'(label_count);
                lt_wdata         = '{bound: 1'b0, pos: '0};
                r_nl             = ID_W'(label_count);
                r_ok             = 1'b1;
                label_count_next = label_count + 1'b1;
              end
            end
            OP_BIND: begin
              if (!lab_alloc) begin
                err_next = 1'b1;
              end else begin
                lt_we = 1'b1;
              end
            end
            OP_EMIT: begin
              do_put = 1'b1;
            end
            OP_BRANCH, OP_BCOND: begin
              do_put = 1'b1;
              if (lab_alloc && lt_rdata.bound) begin
                put_val = enc_word;
              end else begin
                put_val = br_base;
                if (32'(patch_count) >= MAX_PATCHES) begin
                  err_next = 1'b1;
                end else begin
                  pt_we            = 1'b1;
                  patch_count_next = patch_count + 1'b1;
                end
              end
            end
            OP_FINALIZE: begin
              r_fin = !err;
            end
            OP_READ: begin
              r_rd = (32'(raddr_q) < CODE_WORDS) ? ct_rdata : '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_FP_LAB: begin
        lt_re      = 1'b1;
        lt_raddr   = LA_W'(pt_rdata.lab);
        ct_re      = 1'b1;
        ct_raddr   = CA_W'(pt_rdata.at);
        state_next = S_FP_CHK;
      end

      S_FP_CHK: begin
        if (!fp_lab_ok || !lt_rdata.bound || !fp_at_ok) begin
          err_next    = 1'b1;
          fin_ok_next = 1'b0;
          state_next  = S_FIN_OUT;
        end else begin
          ct_we    = 1'b1;
          ct_waddr = CA_W'(pt_rdata.at);
          ct_wdata = enc_word;
          if (fidx == '0) begin
            fin_ok_next = 1'b1;
            state_next  = S_FIN_OUT;
          end else begin
            fidx_next  = fidx - 1'b1;
            pt_re      = 1'b1;
            pt_raddr   = fidx_next;
            state_next = S_FP_LAB;
          end
        end
      end

      S_FIN_OUT: begin
        if (res_ready) begin
          res_valid  = 1'b1;
          r_fin      = fin_ok;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_put) begin
      ct_wdata = put_val;
      if (space_ok) begin
        ct_we          = 1'b1;
        write_pos_next = write_pos + 1'b1;
      end else begin
        err_next = 1'b1;
      end
    end

    res.new_label   = r_nl;
    res.label_ok    = r_ok;
    res.position    = POSO_W'(write_pos_next);
    res.read_data   = r_rd;
    res.error_flag  = err_next;
    res.finalize_ok = r_fin;
  end

endmodule

>>> rtl/branch_label_fixup_emitter_top.sv
// Every op but a walking finalize passes through the S_EXEC state and the output register.
// A finalize with patches to walk goes through S_FP_LAB and S_FP_CHK per patch; each patch costs
// one label read and one code read-modify-write on the registered-read memories.
// A new op is taken only in S_IDLE, so one op at a time; a new op is accepted while a result waits.
// Reset: synchronous, clears counters, error flag, sequencer and output valid;
// memories are not cleared, code_limit returns to 4096.
// ----------------------------------------------------------------------------
// branch_label_fixup_emitter_top
// Branch label fixup emitter: config register, sequencer, output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module branch_label_fixup_emitter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blfe_pkg::OP_W-1:0]     op,
  input  logic [blfe_pkg::ID_W-1:0]     label_id,
  input  logic [blfe_pkg::COND_W-1:0]   cond_code,
  input  logic [blfe_pkg::WORD_W-1:0]   instr_word,
  input  logic [blfe_pkg::RADDR_W-1:0]  read_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blfe_pkg::ID_W-1:0]     new_label,
  output logic                          label_ok,
  output logic [blfe_pkg::POSO_W-1:0]   position,
  output logic [blfe_pkg::WORD_W-1:0]   read_data,
  output logic                          error_flag,
  output logic                          finalize_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blfe_pkg::LIMIT_W-1:0]  cfg_data
);
  import blfe_pkg::*;

  logic [LIMIT_W-1:0] code_limit;
  logic               res_valid, res_ready;
  blfe_res_t          res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      code_limit <= cfg_data;
    end
  end

  blfe_seq u_seq (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .label_id(label_id), .cond_code(cond_code),
    .instr_word(instr_word), .read_addr(read_addr),
    .code_limit(code_limit),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      new_label   <= res.new_label;
      label_ok    <= res.label_ok;
      position    <= res.position;
      read_data   <= res.read_data;
      error_flag  <= res.error_flag;
      finalize_ok <= res.finalize_ok;
    end
  end

  `ASSERT_IMP(a_fin_no_err, out_valid && finalize_ok, !error_flag, "finalize ok with error set")
  `ASSERT_IMP(a_excl_flags, out_valid, !(label_ok && finalize_ok), "label_ok and finalize_ok")
  `ASSERT_NXT(a_err_sticky, out_valid && out_ready && error_flag, !out_valid || error_flag,
              "error flag cleared")
  `ASSERT_NXT(a_one_at_time, in_valid && in_ready, !in_ready, "accepted word while busy")

endmodule

>>> tb/sv/tb_branch_label_fixup_emitter_top.sv
// ----------------------------------------------------------------------------
// tb_branch_label_fixup_emitter_top
// Self-checking bench for the branch label fixup emitter. A shadow assembler
// tracks code image, labels and fixup list and predicts every report word.
// Directed programs and limit extremes come first, then random well-formed
// programs with finalize passes, then overflow and bad-label cases, then noise.
// ----------------------------------------------------------------------------
module tb_branch_label_fixup_emitter_top;
  import blfe_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CLEAN_FIXUPS = 200;
  localparam int CLEAN_LABELS = 196;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    lab;
    logic [COND_W-1:0]  cond;
    logic [WORD_W-1:0]  word;
    logic [RADDR_W-1:0] addr;
  } asm_item_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      op;
  logic [ID_W-1:0]      label_id;
  logic [COND_W-1:0]    cond_code;
  logic [WORD_W-1:0]    instr_word;
  logic [RADDR_W-1:0]   read_addr;
  logic                 out_valid;
  logic                 out_ready;
  logic [ID_W-1:0]      new_label;
  logic                 label_ok;
  logic [POSO_W-1:0]    position;
  logic [WORD_W-1:0]    read_data;
  logic                 error_flag;
  logic                 finalize_ok;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_data;

  branch_label_fixup_emitter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .label_id(label_id), .cond_code(cond_code),
    .instr_word(instr_word), .read_addr(read_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_label(new_label), .label_ok(label_ok), .position(position),
    .read_data(read_data), .error_flag(error_flag), .finalize_ok(finalize_ok),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow assembler state
  logic [WORD_W-1:0]  img_mem [CODE_WORDS];
  logic [POS_W-1:0]   img_pos;
  logic               img_err;
  logic [LIMIT_W-1:0] img_limit;
  logic [LCNT_W-1:0]  lbl_cnt;
  logic               lbl_bound [MAX_LABELS];
  logic [POS_W-1:0]   lbl_at [MAX_LABELS];
  logic [ID_W-1:0]    fix_lab [MAX_PATCHES];
  logic [POS_W-1:0]   fix_at [MAX_PATCHES];
  logic               fix_cond [MAX_PATCHES];
  logic [PCNT_W-1:0]  fix_cnt;

  blfe_res_t asm_reports[$];
  blfe_res_t want_res;

  int errors = 0;
  int items_sent = 0;
  int reports_seen = 0;
  int fin_passes = 0;
  int cfg_writes = 0;
  int burst_left = 1;
  int gap_max = 6;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;
  int unsigned cyc = 0;

  function automatic int cur_limit();
    return (img_limit > CODE_WORDS) ? CODE_WORDS : int'(img_limit);
  endfunction

  function automatic void put_code(input logic [WORD_W-1:0] w);
    if (int'(img_pos) + 1 > cur_limit()) begin
      img_err = 1'b1;
    end else begin
      img_mem[img_pos[CA_W-1:0]] = w;
      img_pos++;
    end
  endfunction

  function automatic bit fits(input int off, input bit c);
    int lim = c ? (1 << 18) : (1 << 25);
    return (off >= -lim) && (off < lim);
  endfunction

  function automatic logic [WORD_W-1:0] pack_branch(input logic [WORD_W-1:0] base,
                                                    input int off, input bit c);
    logic [WORD_W-1:0] u;
    u = off;
    if (c) return (base & BC_KEEP) | ((u & 32'h0007_FFFF) << OFF_C_LSB);
    return (base & B_KEEP) | (u & 32'h03FF_FFFF);
  endfunction

  function automatic void branch_to(input logic [ID_W-1:0] lab,
                                    input logic [COND_W-1:0] cond, input bit c);
    logic [WORD_W-1:0] base;
    int off;
    base = c ? (BC_BASE | WORD_W'(cond)) : B_BASE;
    if (lab < lbl_cnt && lbl_bound[lab]) begin
      off = int'(lbl_at[lab]) - int'(img_pos);
      if (!fits(off, c)) img_err = 1'b1;
      else put_code(pack_branch(base, off, c));
    end else begin
      if (fix_cnt >= MAX_PATCHES) begin
        img_err = 1'b1;
      end else begin
        fix_lab[fix_cnt[PA_W-1:0]] = lab;
        fix_at[fix_cnt[PA_W-1:0]] = img_pos;
        fix_cond[fix_cnt[PA_W-1:0]] = c;
        fix_cnt++;
      end
      put_code(base);
    end
  endfunction

  // newest fixup first, stop at the first unresolvable one
  function automatic bit walk_fixups();
    logic [PA_W-1:0] idx;
    int off;
    logic [ID_W-1:0] l;
    logic [POS_W-1:0] a;
    if (img_err) return 1'b0;
    for (int i = int'(fix_cnt); i > 0; i--) begin
      idx = PA_W'(i - 1);
      l = fix_lab[idx];
      a = fix_at[idx];
      if (l >= lbl_cnt || !lbl_bound[l] || a >= CODE_WORDS) begin
        img_err = 1'b1;
        return 1'b0;
      end
      off = int'(lbl_at[l]) - int'(a);
      if (!fits(off, fix_cond[idx])) begin
        img_err = 1'b1;
        return 1'b0;
      end
      img_mem[a[CA_W-1:0]] = pack_branch(img_mem[a[CA_W-1:0]], off, fix_cond[idx]);
    end
    return 1'b1;
  endfunction

  function automatic void run_asm_op(input asm_item_t it);
    blfe_res_t r;
    r = '0;
    case (it.op)
      OP_NEW_LABEL: begin
        if (lbl_cnt >= MAX_LABELS) begin
          img_err = 1'b1;
        end else begin
          lbl_bound[lbl_cnt[LA_W-1:0]] = 1'b0;
          r.new_label = lbl_cnt[ID_W-1:0];
          r.label_ok = 1'b1;
          lbl_cnt++;
        end
      end
      OP_BIND: begin
        if (it.lab >= lbl_cnt) begin
          img_err = 1'b1;
        end else begin
          lbl_at[it.lab] = img_pos;
          lbl_bound[it.lab] = 1'b1;
        end
      end
      OP_EMIT: put_code(it.word);
      OP_BRANCH: branch_to(it.lab, it.cond, 1'b0);
      OP_BCOND: branch_to(it.lab, it.cond, 1'b1);
      OP_FINALIZE: begin
        r.finalize_ok = walk_fixups();
        if (r.finalize_ok) fin_passes++;
      end
      OP_READ: r.read_data = img_mem[it.addr];
      default: ;
    endcase
    r.position = img_pos;
    r.error_flag = img_err;
    asm_reports.push_back(r);
  endfunction

  function automatic asm_item_t rand_item(input logic [OP_W-1:0] o);
    asm_item_t it;
    it.op = o;
    it.lab = ID_W'($urandom);
    it.cond = COND_W'($urandom);
    it.word = $urandom;
    it.addr = RADDR_W'($urandom);
    if (o == OP_READ && img_pos > 0) begin
      it.addr = RADDR_W'($urandom_range(0, int'(img_pos) - 1));
    end
    return it;
  endfunction

  task automatic send_item(input asm_item_t it);
    int g;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= it.op;
    label_id <= it.lab;
    cond_code <= it.cond;
    instr_word <= it.word;
    read_addr <= it.addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    run_asm_op(it);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      g = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (g > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_op(input logic [OP_W-1:0] o, input logic [ID_W-1:0] lab,
                         input logic [COND_W-1:0] cond, input logic [WORD_W-1:0] word,
                         input logic [RADDR_W-1:0] addr);
    asm_item_t it;
    it.op = o;
    it.lab = lab;
    it.cond = cond;
    it.word = word;
    it.addr = addr;
    send_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (asm_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    img_limit = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic cmp_field(input string name, input logic [WORD_W-1:0] exp_v,
                           input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (asm_reports.size() == 0) begin
        $display("%0t: unexpected report word, expected none actual position %0h",
                 $time, position);
        errors++;
      end else begin
        want_res = asm_reports.pop_front();
        reports_seen++;
        cmp_field("new_label", WORD_W'(want_res.new_label), WORD_W'(new_label));
        cmp_field("label_ok", WORD_W'(want_res.label_ok), WORD_W'(label_ok));
        cmp_field("position", WORD_W'(want_res.position), WORD_W'(position));
        cmp_field("read_data", want_res.read_data, read_data);
        cmp_field("error_flag", WORD_W'(want_res.error_flag), WORD_W'(error_flag));
        cmp_field("finalize_ok", WORD_W'(want_res.finalize_ok), WORD_W'(finalize_ok));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 150);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ((rx_phase % 3) != 0);
      endcase
    end
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("branch_label_fixup_emitter_top regression: fail");
    $finish;
  end

  task automatic test_empty_start();
    send_op(OP_SPARE, 8'hFF, 4'hF, 32'hFFFF_FFFF, 12'hFFF);
    send_op(OP_FINALIZE, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_NEW_LABEL, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_NEW_LABEL, 8'd0, 4'd0, 32'd0, 12'd0);
  endtask

  task automatic test_backward_branches();
    send_op(OP_BIND, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_EMIT, 8'd0, 4'd0, 32'h0000_0000, 12'd0);
    send_op(OP_EMIT, 8'hFF, 4'hF, 32'hFFFF_FFFF, 12'hFFF);
    send_op(OP_BRANCH, 8'd0, 4'hF, 32'd0, 12'd0);
    send_op(OP_BCOND, 8'd0, 4'hF, 32'd0, 12'd0);
    send_op(OP_BCOND, 8'd0, 4'h0, 32'd0, 12'd0);
    send_op(OP_BIND, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_BRANCH, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, 12'd3);
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, 12'd5);
  endtask

  task automatic test_forward_refs();
    int fwd;
    int at_b;
    send_op(OP_NEW_LABEL, 8'd0, 4'd0, 32'd0, 12'd0);
    fwd = int'(lbl_cnt) - 1;
    at_b = int'(img_pos);
    send_op(OP_BRANCH, ID_W'(fwd), 4'd0, 32'd0, 12'd0);
    send_op(OP_BCOND, 8'd1, 4'd9, 32'd0, 12'd0);
    send_op(OP_EMIT, 8'd0, 4'd0, $urandom, 12'd0);
    send_op(OP_BIND, ID_W'(fwd), 4'd0, 32'd0, 12'd0);
    send_op(OP_EMIT, 8'd0, 4'd0, $urandom, 12'd0);
    send_op(OP_BIND, 8'd1, 4'd0, 32'd0, 12'd0);
    send_op(OP_FINALIZE, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, RADDR_W'(at_b));
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, RADDR_W'(at_b + 1));
    send_op(OP_FINALIZE, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, RADDR_W'(at_b + 1));
  endtask

  task automatic test_limit_high();
    write_limit(13'h1FFF);
    send_item(rand_item(OP_EMIT));
    send_item(rand_item(OP_EMIT));
    write_limit(LIMIT_W'(CODE_WORDS));
    send_item(rand_item(OP_EMIT));
    send_item(rand_item(OP_READ));
  endtask

  // well-formed programs: every fixup target gets bound before a finalize
  task automatic test_clean_programs(input int n);
    int sent0;
    int blocks;
    int nb;
    int pick;
    int blk[3];
    asm_item_t it;
    sent0 = items_sent;
    blocks = 0;
    while (items_sent - sent0 < n) begin
      blocks++;
      if (blocks == 4) begin
        gap_max = 0;
        @(posedge clk);
        hold_left = 300;
      end
      if (blocks == 9) gap_max = 6;
      if (blocks % 11 == 0) wait_idle();
      if (blocks % 13 == 0) write_limit(LIMIT_W'($urandom_range(CODE_WORDS, 8191)));
      nb = (lbl_cnt <= CLEAN_LABELS) ? $urandom_range(1, 3) : 0;
      for (int k = 0; k < nb; k++) begin
        send_item(rand_item(OP_NEW_LABEL));
        blk[k] = int'(lbl_cnt) - 1;
      end
      repeat ($urandom_range(4, 20)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40 || lbl_cnt == 0) begin
          send_item(rand_item(OP_EMIT));
        end else if (pick < 70) begin
          it = rand_item($urandom_range(0, 1) ? OP_BRANCH : OP_BCOND);
          it.lab = ID_W'($urandom_range(0, int'(lbl_cnt) - 1));
          if (!lbl_bound[it.lab] && fix_cnt >= CLEAN_FIXUPS) it = rand_item(OP_EMIT);
          send_item(it);
        end else if (pick < 82) begin
          it = rand_item(OP_BIND);
          it.lab = ID_W'($urandom_range(0, int'(lbl_cnt) - 1));
          send_item(it);
        end else if (pick < 95 && img_pos > 0) begin
          send_item(rand_item(OP_READ));
        end else begin
          send_item(rand_item(OP_SPARE));
        end
      end
      for (int k = 0; k < nb; k++) begin
        if (!lbl_bound[ID_W'(blk[k])]) begin
          it = rand_item(OP_BIND);
          it.lab = ID_W'(blk[k]);
          send_item(it);
        end
      end
      if ($urandom_range(0, 99) < 40) send_item(rand_item(OP_FINALIZE));
    end
    gap_max = 6;
  endtask

  task automatic test_finalize_unbound();
    int l;
    send_item(rand_item(OP_NEW_LABEL));
    l = int'(lbl_cnt) - 1;
    send_op(OP_BCOND, ID_W'(l), COND_W'($urandom), 32'd0, 12'd0);
    send_op(OP_FINALIZE, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_FINALIZE, 8'd0, 4'd0, 32'd0, 12'd0);
  endtask

  task automatic test_error_paths();
    asm_item_t it;
    send_op(OP_BIND, lbl_cnt[ID_W-1:0], 4'd0, 32'd0, 12'd0);
    send_op(OP_BRANCH, 8'hFF, 4'd0, 32'd0, 12'd0);
    send_op(OP_BCOND, 8'hFE, 4'h5, 32'd0, 12'd0);
    // code store full
    write_limit(img_pos);
    send_item(rand_item(OP_EMIT));
    send_op(OP_BRANCH, 8'd0, 4'd0, 32'd0, 12'd0);
    send_op(OP_BCOND, 8'hFF, 4'hA, 32'd0, 12'd0);
    send_item(rand_item(OP_FINALIZE));
    send_item(rand_item(OP_READ));
    write_limit(13'd0);
    send_item(rand_item(OP_EMIT));
    send_op(OP_READ, 8'd0, 4'd0, 32'd0, 12'd0);
    write_limit(LIMIT_W'(CODE_WORDS));
    // label table full
    while (lbl_cnt < MAX_LABELS) send_item(rand_item(OP_NEW_LABEL));
    send_item(rand_item(OP_NEW_LABEL));
    send_item(rand_item(OP_NEW_LABEL));
    // fixup list full, placeholders still land
    while (fix_cnt < MAX_PATCHES + 3) begin
      it = rand_item($urandom_range(0, 1) ? OP_BRANCH : OP_BCOND);
      it.lab = ID_W'(MAX_LABELS - 1);
      send_item(it);
      if (fix_cnt == MAX_PATCHES) break;
    end
    repeat (3) begin
      it = rand_item($urandom_range(0, 1) ? OP_BRANCH : OP_BCOND);
      it.lab = ID_W'(MAX_LABELS - 1);
      send_item(it);
    end
    send_item(rand_item(OP_READ));
  endtask

  task automatic test_random_noise(input int n);
    logic [OP_W-1:0] o;
    for (int i = 0; i < n; i++) begin
      if (i % 70 == 69) begin
        case ($urandom_range(0, 3))
          0: write_limit(13'd0);
          1: write_limit(13'h1FFF);
          2: write_limit(LIMIT_W'(CODE_WORDS));
          default: write_limit(LIMIT_W'($urandom_range(0, 8191)));
        endcase
      end
      o = OP_W'($urandom_range(0, 7));
      if (o == OP_READ && img_pos == 0) o = OP_SPARE;
      send_item(rand_item(o));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    label_id = '0;
    cond_code = '0;
    instr_word = '0;
    read_addr = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    img_pos = '0;
    img_err = 1'b0;
    img_limit = LIMIT_RESET;
    lbl_cnt = '0;
    fix_cnt = '0;
    for (int i = 0; i < MAX_LABELS; i++) begin
      lbl_bound[i] = 1'b0;
      lbl_at[i] = '0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_start();
    test_backward_branches();
    test_forward_refs();
    test_limit_high();
    test_clean_programs(880);
    test_finalize_unbound();
    test_error_paths();
    test_random_noise(360);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("%0d ops, %0d reports checked, %0d clean finalize passes, %0d limit writes",
             items_sent, reports_seen, fin_passes, cfg_writes);
    $display("end state: position %0d, %0d labels, %0d fixups, error flag %0b",
             img_pos, lbl_cnt, fix_cnt, img_err);
    if (errors == 0) begin
      $display("branch_label_fixup_emitter_top regression: pass");
    end else begin
      $display("branch_label_fixup_emitter_top regression: fail");
    end
    $finish;
  end

endmodule
